>>> design/rrop_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrop_pkg
// Shared types and constants for the rounded rectangle outline vertex pipeline.
// ----------------------------------------------------------------------------
package rrop_pkg;

  // coordinate and field widths (4 fraction bits throughout)
  localparam int COORD_W   = 16;
  localparam int OUT_W     = 17;
  localparam int IDX_W     = 8;
  localparam int STEP_W    = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CALC_W    = 19;
  localparam int SQ_W      = 2 * COORD_W;
  localparam int ROOT_W    = COORD_W;

  // corner order along the outline
  typedef enum logic [1:0] {
    CORNER_TR,
    CORNER_BR,
    CORNER_BL,
    CORNER_TL
  } corner_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X = 3'd0,
    CFG_ORIGIN_Y = 3'd1,
    CFG_RECT_W   = 3'd2,
    CFG_RECT_H   = 3'd3,
    CFG_RADIUS   = 3'd4
  } cfg_reg_t;

  // shape geometry held in configuration registers
  typedef struct packed {
    logic [COORD_W-1:0] origin_x;
    logic [COORD_W-1:0] origin_y;
    logic [COORD_W-1:0] rect_width;
    logic [COORD_W-1:0] rect_height;
    logic [COORD_W-1:0] corner_radius;
  } cfg_t;

  // per-request data that rides alongside the root computation
  typedef struct packed {
    corner_t            corner;
    logic [COORD_W-1:0] step_ofs;
  } side_t;

endpackage

>>> design/rounded_rect_outline_points_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rounded_rect_outline_points_core
// Rounded rectangle outline vertex generator, one vertex per request.
// ----------------------------------------------------------------------------
// Takes one vertex request per clock while in_stall is low: 5 stages
// compute the step offset and the radicand, 8 stages resolve the square
// root two bits per stage and one stage places and registers the vertex.
// The corner arc radius and the rectangle geometry come from the
// configuration registers, which should be written only while no request
// is in flight. Bits 7..6 of the index select the corner (top-right,
// bottom-right, bottom-left, top-left), bits 5..0 the arc step; steps past
// the last arc sample return the last sample. Stalls fill empty pipeline
// slots first, so input stalls only once every stage holds a request.
module rounded_rect_outline_points_core
  import rrop_pkg::*;
#(
  parameter int ARC_STEPS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [IDX_W-1:0]     in_point_index,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [OUT_W-1:0]     out_point_x,
  output logic [OUT_W-1:0]     out_point_y
);

  cfg_t              cfg_r;
  logic              arc_rdy, sqrt_rdy, coord_rdy;
  logic              arc_valid, sqrt_valid;
  logic [SQ_W-1:0]   arc_diff;
  side_t             arc_side, sqrt_side;
  logic [ROOT_W-1:0] sqrt_root;

  // configuration registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_ORIGIN_X: cfg_r.origin_x      <= cfg_wdata;
        CFG_ORIGIN_Y: cfg_r.origin_y      <= cfg_wdata;
        CFG_RECT_W:   cfg_r.rect_width    <= cfg_wdata;
        CFG_RECT_H:   cfg_r.rect_height   <= cfg_wdata;
        CFG_RADIUS:   cfg_r.corner_radius <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_stall = !arc_rdy;

  rrop_arc_offset #(
    .ARC_STEPS(ARC_STEPS)
  ) u_arc (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_point_index(in_point_index),
    .up_rdy        (arc_rdy),
    .out_valid     (arc_valid),
    .out_diff      (arc_diff),
    .out_side      (arc_side),
    .dn_rdy        (sqrt_rdy)
  );

  rrop_sqrt_pipe u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (arc_valid),
    .in_rad   (arc_diff),
    .in_side  (arc_side),
    .up_rdy   (sqrt_rdy),
    .out_valid(sqrt_valid),
    .out_root (sqrt_root),
    .out_side (sqrt_side),
    .dn_rdy   (coord_rdy)
  );

  rrop_coord u_coord (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (sqrt_valid),
    .in_root    (sqrt_root),
    .in_side    (sqrt_side),
    .up_rdy     (coord_rdy),
    .out_valid  (out_valid),
    .out_point_x(out_point_x),
    .out_point_y(out_point_y),
    .out_stall  (out_stall)
  );

endmodule

>>> design/rrop_arc_offset.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrop_arc_offset
// Five-stage front end: arc step, step offset r*(k+1)/ARC_STEPS through a
// reciprocal multiply, the two squares and their difference r^2 - s^2.
// ----------------------------------------------------------------------------
module rrop_arc_offset
  import rrop_pkg::*;
#(
  parameter int ARC_STEPS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             in_valid,
  input  logic [IDX_W-1:0] in_point_index,
  output logic             up_rdy,
  output logic             out_valid,
  output logic [SQ_W-1:0]  out_diff,
  output side_t            out_side,
  input  logic             dn_rdy
);

  localparam int K1_W      = STEP_W + 1;
  localparam int P_W       = COORD_W + K1_W;
  localparam int DIV_SHIFT = P_W + $clog2(ARC_STEPS);
  localparam int RECIP_W   = P_W + 1;
  localparam int QP_W      = P_W + RECIP_W;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << DIV_SHIFT) + 64'(ARC_STEPS) - 64'd1) / 64'(ARC_STEPS);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

  logic                v0_r, v1_r, v2_r, v3_r, v4_r;
  logic                en0, en1, en2, en3, en4;
  logic [K1_W-1:0]     k1_r, k1_nxt;
  corner_t             corner0_r, corner1_r, corner2_r;
  logic [P_W-1:0]      prod_r, prod_nxt;
  logic [COORD_W-1:0]  s2_r, s2_nxt;
  logic [QP_W-1:0]     qprod;
  logic [SQ_W-1:0]     s_sq_r, s_sq_nxt, r_sq_r, r_sq_nxt;
  side_t               side3_r, side4_r;
  logic [SQ_W-1:0]     diff_r, diff_nxt;
  logic [STEP_W-1:0]   k;
  logic                k_sat;

  // a stage moves when it is empty or the one after it moves
  assign en4    = !v4_r || dn_rdy;
  assign en3    = !v3_r || en4;
  assign en2    = !v2_r || en3;
  assign en1    = !v1_r || en2;
  assign en0    = !v0_r || en1;
  assign up_rdy = en0;

  // arc step saturates at the last sample
  assign k      = in_point_index[STEP_W-1:0];
  assign k_sat  = (32'(k) >= 32'(ARC_STEPS - 1));
  assign k1_nxt = k_sat ? K1_W'(ARC_STEPS) : (K1_W'(k) + K1_W'(1));

  // radius times step count
  assign prod_nxt = P_W'(cfg.corner_radius) * P_W'(k1_r);

  // exact floor division by ARC_STEPS through a rounded-up reciprocal
  assign qprod  = QP_W'(prod_r) * QP_W'(RECIP);
  assign s2_nxt = qprod[DIV_SHIFT +: COORD_W];

  // squares of step offset and radius
  assign s_sq_nxt = SQ_W'(s2_r) * SQ_W'(s2_r);
  assign r_sq_nxt = SQ_W'(cfg.corner_radius) * SQ_W'(cfg.corner_radius);

  // radicand, never negative since s <= r
  assign diff_nxt = r_sq_r - s_sq_r;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en0) v0_r <= in_valid;
      if (en1) v1_r <= v0_r;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (en0 && in_valid) begin
      k1_r      <= k1_nxt;
      corner0_r <= corner_t'(in_point_index[IDX_W-1 -: 2]);
    end
    if (en1 && v0_r) begin
      prod_r    <= prod_nxt;
      corner1_r <= corner0_r;
    end
    if (en2 && v1_r) begin
      s2_r      <= s2_nxt;
      corner2_r <= corner1_r;
    end
    if (en3 && v2_r) begin
      s_sq_r           <= s_sq_nxt;
      r_sq_r           <= r_sq_nxt;
      side3_r.corner   <= corner2_r;
      side3_r.step_ofs <= s2_r;
    end
    if (en4 && v3_r) begin
      diff_r  <= diff_nxt;
      side4_r <= side3_r;
    end
  end

  assign out_valid = v4_r;
  assign out_diff  = diff_r;
  assign out_side  = side4_r;

endmodule

>>> design/rrop_sqrt_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrop_sqrt_pipe
// Pipelined restoring integer square root, two result bits per stage.
// ----------------------------------------------------------------------------
module rrop_sqrt_pipe
  import rrop_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [SQ_W-1:0]   in_rad,
  input  side_t             in_side,
  output logic              up_rdy,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output side_t             out_side,
  input  logic              dn_rdy
);

  localparam int DIGITS = 2;
  localparam int STAGES = ROOT_W / DIGITS;
  localparam int REM_W  = ROOT_W + 4;

  typedef struct packed {
    logic [SQ_W-1:0]   rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_st_t;

  // one result bit: bring down two radicand bits, try to subtract 4*root+1
  function automatic sqrt_st_t sqrt_step(input sqrt_st_t a);
    sqrt_st_t         b;
    logic [REM_W-1:0] acc;
    logic [REM_W-1:0] trial;
    acc   = {a.rem[REM_W-3:0], a.rad[SQ_W-1 -: 2]};
    trial = {{(REM_W-ROOT_W-2){1'b0}}, a.root, 2'b01};
    b.rad = {a.rad[SQ_W-3:0], 2'b00};
    if (acc >= trial) begin
      b.rem  = acc - trial;
      b.root = {a.root[ROOT_W-2:0], 1'b1};
    end else begin
      b.rem  = acc;
      b.root = {a.root[ROOT_W-2:0], 1'b0};
    end
    return b;
  endfunction

  logic     v_r [STAGES];
  sqrt_st_t st_r [STAGES];
  side_t    side_r [STAGES];
  logic     en [STAGES];
  logic     vin [STAGES];
  sqrt_st_t src [STAGES];
  sqrt_st_t res [STAGES];
  side_t    side_in [STAGES];

  // stall chain from the last stage back to the first
  always_comb begin
    for (int j = STAGES - 1; j >= 0; j--) begin
      if (j == STAGES - 1) begin
        en[j] = !v_r[j] || dn_rdy;
      end else begin
        en[j] = !v_r[j] || en[j+1];
      end
    end
  end

  // stage inputs and the two digit steps of each stage
  always_comb begin
    for (int j = 0; j < STAGES; j++) begin
      if (j == 0) begin
        src[j].rad  = in_rad;
        src[j].rem  = '0;
        src[j].root = '0;
        vin[j]      = in_valid;
        side_in[j]  = in_side;
      end else begin
        src[j]     = st_r[j-1];
        vin[j]     = v_r[j-1];
        side_in[j] = side_r[j-1];
      end
      res[j] = src[j];
      for (int d = 0; d < DIGITS; d++) begin
        res[j] = sqrt_step(res[j]);
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < STAGES; j++) begin
        v_r[j] <= 1'b0;
      end
    end else begin
      for (int j = 0; j < STAGES; j++) begin
        if (en[j]) v_r[j] <= vin[j];
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    for (int j = 0; j < STAGES; j++) begin
      if (en[j] && vin[j]) begin
        st_r[j]   <= res[j];
        side_r[j] <= side_in[j];
      end
    end
  end

  assign up_rdy    = en[0];
  assign out_valid = v_r[STAGES-1];
  assign out_root  = st_r[STAGES-1].root;
  assign out_side  = side_r[STAGES-1];

endmodule

>>> design/rrop_coord.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrop_coord
// Places the two arc offsets at the selected corner, clamps below zero and
// holds the vertex in the output register.
// ----------------------------------------------------------------------------
module rrop_coord
  import rrop_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              in_valid,
  input  logic [ROOT_W-1:0] in_root,
  input  side_t             in_side,
  output logic              up_rdy,
  output logic              out_valid,
  output logic [OUT_W-1:0]  out_point_x,
  output logic [OUT_W-1:0]  out_point_y,
  input  logic              out_stall
);

  // negative sums go to zero; the upper end cannot be exceeded
  function automatic logic [OUT_W-1:0] clamp_coord(input logic signed [CALC_W-1:0] v);
    logic [OUT_W-1:0] res;
    if (v < 0) begin
      res = '0;
    end else begin
      res = v[OUT_W-1:0];
    end
    return res;
  endfunction

  logic                     out_valid_r;
  logic [OUT_W-1:0]         px_r, py_r;
  logic signed [CALC_W-1:0] ox, oy, rgt, bot, rad, s, c, px, py;

  assign ox  = $signed(CALC_W'(cfg.origin_x));
  assign oy  = $signed(CALC_W'(cfg.origin_y));
  assign rgt = ox + $signed(CALC_W'(cfg.rect_width));
  assign bot = oy + $signed(CALC_W'(cfg.rect_height));
  assign rad = $signed(CALC_W'(cfg.corner_radius));
  assign s   = $signed(CALC_W'(in_side.step_ofs));
  assign c   = $signed(CALC_W'(in_root));

  // corner placement
  always_comb begin
    case (in_side.corner)
      CORNER_TR: begin
        px = rgt - rad + s;
        py = oy + rad - c;
      end
      CORNER_BR: begin
        px = rgt - rad + c;
        py = bot - rad + s;
      end
      CORNER_BL: begin
        px = ox + rad - s;
        py = bot - rad + c;
      end
      default: begin
        px = ox + rad - c;
        py = oy + rad - s;
      end
    endcase
  end

  assign up_rdy = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (up_rdy) begin
      out_valid_r <= in_valid;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (up_rdy && in_valid) begin
      px_r <= clamp_coord(px);
      py_r <= clamp_coord(py);
    end
  end

  assign out_valid   = out_valid_r;
  assign out_point_x = px_r;
  assign out_point_y = py_r;

endmodule

>>> design/rrop_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrop_checker
// Port-level checks for the rounded rectangle outline vertex generator.
// ----------------------------------------------------------------------------
module rrop_checker
  import rrop_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [OUT_W-1:0] out_point_x,
  input logic [OUT_W-1:0] out_point_y
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // a stalled vertex holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_point_x) && $stable(out_point_y))
    else $error("stalled vertex changed");

  // input backs up only behind a stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked output");

  // with the output free, the input side is not blocked in the same cycle
  a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output is free");

  // a vertex does not appear straight out of reset
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(rst_n))
    else $error("vertex emitted straight out of reset");

endmodule

bind rounded_rect_outline_points_core rrop_checker u_rrop_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_point_x(out_point_x),
  .out_point_y(out_point_y)
);

>>> verif/rrop_vertex_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrop_vertex_checker
// Watches the configuration port and both request channels of the rounded
// rectangle outline core, predicts every vertex from its own copy of the
// geometry registers and compares each returned vertex, in order, against
// the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module rrop_vertex_checker
  import rrop_pkg::*;
#(
  parameter int ARC_STEPS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_wdata,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [IDX_W-1:0]     in_point_index,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [OUT_W-1:0]     out_point_x,
  input  logic [OUT_W-1:0]     out_point_y,
  output int                   fail_count,
  output int                   outstanding
);

  typedef struct packed {
    logic [OUT_W-1:0] x;
    logic [OUT_W-1:0] y;
  } vertex_t;

  cfg_t    geom;
  vertex_t pending_vertices[$];
  vertex_t want;

  // integer floor square root, one result bit per iteration
  function automatic logic [ROOT_W-1:0] floor_root(input longint radicand);
    logic [ROOT_W-1:0] root;
    logic [ROOT_W-1:0] trial;
    root = '0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      trial = root | (ROOT_W'(1) << b);
      if (longint'(trial) * longint'(trial) <= radicand) root = trial;
    end
    return root;
  endfunction

  // negative sums pin to zero, oversize sums to the top of the range
  function automatic logic [OUT_W-1:0] clamp_coord(input longint v);
    if (v < 0) return '0;
    if (v > longint'({OUT_W{1'b1}})) return '1;
    return v[OUT_W-1:0];
  endfunction

  // vertex for one request under the given geometry
  function automatic vertex_t place_vertex(input logic [IDX_W-1:0] idx, input cfg_t g);
    longint  step, r, s, c;
    longint  left, top, right, bottom, px, py;
    vertex_t v;
    step = longint'(idx[STEP_W-1:0]);
    if (step > longint'(ARC_STEPS - 1)) step = longint'(ARC_STEPS - 1);
    r = longint'(g.corner_radius);
    s = (r * (step + 1)) / ARC_STEPS;
    if (s > r) s = r;
    c = longint'(floor_root(r * r - s * s));
    left   = longint'(g.origin_x);
    top    = longint'(g.origin_y);
    right  = left + longint'(g.rect_width);
    bottom = top + longint'(g.rect_height);
    case (corner_t'(idx[IDX_W-1 -: 2]))
      CORNER_TR: begin
        px = right - r + s;
        py = top + r - c;
      end
      CORNER_BR: begin
        px = right - r + c;
        py = bottom - r + s;
      end
      CORNER_BL: begin
        px = left + r - s;
        py = bottom - r + c;
      end
      default: begin
        px = left + r - c;
        py = top + r - s;
      end
    endcase
    v.x = clamp_coord(px);
    v.y = clamp_coord(py);
    return v;
  endfunction

  // shadow registers, prediction and in-order compare
  always @(posedge clk) begin
    if (!rst_n) begin
      geom = '0;
      pending_vertices.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_vertices.size() == 0) begin
          $display("%0t: vertex (%0d, %0d) returned with no request waiting",
                   $time, out_point_x, out_point_y);
          fail_count++;
        end else begin
          want = pending_vertices.pop_front();
          if (out_point_x !== want.x) begin
            $display("%0t: point_x mismatch, expected %0d, got %0d",
                     $time, want.x, out_point_x);
            fail_count++;
          end
          if (out_point_y !== want.y) begin
            $display("%0t: point_y mismatch, expected %0d, got %0d",
                     $time, want.y, out_point_y);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) pending_vertices.push_back(place_vertex(in_point_index, geom));
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_ORIGIN_X: geom.origin_x      = cfg_wdata;
          CFG_ORIGIN_Y: geom.origin_y      = cfg_wdata;
          CFG_RECT_W:   geom.rect_width    = cfg_wdata;
          CFG_RECT_H:   geom.rect_height   = cfg_wdata;
          CFG_RADIUS:   geom.corner_radius = cfg_wdata;
          default: ;
        endcase
      end
    end
    outstanding = pending_vertices.size();
  end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Regression for rounded_rect_outline_points_core: a directed sweep over the
// corners, arc ends and clamping cases, then randomized geometry phases with
// random vertex requests, bursty idling on both channels, one long output
// hold and one mid-phase drain, all checked by rrop_vertex_checker.
// ----------------------------------------------------------------------------
module tb;
  import rrop_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam int PHASE_COUNT = 10;
  localparam int PHASE_REQS  = 85;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COORD_W-1:0]   cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic [IDX_W-1:0]     in_point_index;
  logic                 out_valid;
  logic                 out_stall;
  logic [OUT_W-1:0]     out_point_x;
  logic [OUT_W-1:0]     out_point_y;
  int                   fail_count;
  int                   outstanding;

  bit idle_on;
  bit stall_on;
  bit long_hold_req;
  int long_hold_cycles;

  logic [IDX_W-1:0] corner_sweep[8] = '{8'd0, 8'd63, 8'd64, 8'd127,
                                        8'd128, 8'd191, 8'd192, 8'd255};

  rounded_rect_outline_points_core i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_point_index(in_point_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_point_x   (out_point_x),
    .out_point_y   (out_point_y)
  );

  rrop_vertex_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_point_index(in_point_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_point_x   (out_point_x),
    .out_point_y   (out_point_y),
    .fail_count    (fail_count),
    .outstanding   (outstanding)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run limit
  initial begin
    #2_000_000;
    $display("rounded_rect_outline_points_core regression: fail");
    $finish;
  end

  // result side: random stall bursts, plus one long hold on demand
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (long_hold_cycles) @(negedge clk);
        long_hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (stall_on && $urandom_range(0, 6) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_geometry(input logic [COORD_W-1:0] ox, input logic [COORD_W-1:0] oy,
                              input logic [COORD_W-1:0] w, input logic [COORD_W-1:0] h,
                              input logic [COORD_W-1:0] r);
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_RECT_W, w);
    write_reg(CFG_RECT_H, h);
    write_reg(CFG_RADIUS, r);
  endtask

  // one vertex request, with an optional idle burst ahead of it
  task automatic send_vertex(input logic [IDX_W-1:0] idx);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_point_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop offering and wait for every predicted vertex to come back
  task automatic drain_requests();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (outstanding == 0);
  endtask

  task automatic random_geometry();
    int w, h, r;
    case ($urandom_range(0, 3))
      0: set_geometry(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                      COORD_W'($urandom), COORD_W'($urandom));
      1: begin
        w = $urandom_range(64, 8000);
        h = $urandom_range(64, 8000);
        r = $urandom_range(0, ((w < h) ? w : h) / 2);
        set_geometry(COORD_W'($urandom_range(0, 20000)), COORD_W'($urandom_range(0, 20000)),
                     COORD_W'(w), COORD_W'(h), COORD_W'(r));
      end
      2: set_geometry($urandom_range(0, 1) ? 16'hFFFF : 16'h0000,
                      $urandom_range(0, 1) ? 16'hFFFF : 16'h0000,
                      $urandom_range(0, 1) ? 16'hFFFF : 16'h0000,
                      $urandom_range(0, 1) ? 16'hFFFF : 16'h0000,
                      $urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
      default: set_geometry(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                            COORD_W'($urandom), COORD_W'($urandom_range(0, 63)));
    endcase
    // writes to unmapped indexes must leave the geometry alone
    if ($urandom_range(0, 1)) write_reg(CFG_IDX_W'($urandom_range(5, 7)), COORD_W'($urandom));
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_point_index = '0;
    idle_on        = 1'b1;
    stall_on       = 1'b1;
    long_hold_req  = 1'b0;
    long_hold_cycles = 60;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // geometry straight out of reset
    send_vertex(8'd0);
    send_vertex(8'd255);
    drain_requests();

    // ordinary rectangle, all corners at both arc ends
    set_geometry(16'd1600, 16'd800, 16'd6400, 16'd3200, 16'd480);
    write_reg(CFG_UNUSED, 16'hFFFF);
    foreach (corner_sweep[i]) send_vertex(corner_sweep[i]);
    drain_requests();

    // every register at full scale
    set_geometry(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_vertex(8'd0);
    send_vertex(8'd63);
    send_vertex(8'd192);
    send_vertex(8'd255);
    drain_requests();

    // radius far beyond the rectangle, coordinates go negative and clamp
    set_geometry(16'd0, 16'd0, 16'd16, 16'd16, 16'hFFFF);
    foreach (corner_sweep[i]) send_vertex(corner_sweep[i]);
    drain_requests();

    // random geometry phases
    for (int p = 0; p < PHASE_COUNT; p++) begin
      if (p == PHASE_COUNT - 1) begin
        idle_on  = 1'b0;
        stall_on = 1'b0;
      end
      random_geometry();
      for (int n = 0; n < PHASE_REQS; n++) begin
        // long output hold while requests keep coming, to back up the pipe
        if (p == 2 && n == PHASE_REQS / 3) long_hold_req = 1'b1;
        if (p == 5 && n == PHASE_REQS / 2) drain_requests();
        send_vertex(IDX_W'($urandom_range(0, 255)));
      end
      drain_requests();
    end

    repeat (30) @(posedge clk);
    if (fail_count == 0) begin
      $display("rounded_rect_outline_points_core regression: pass");
    end else begin
      $display("rounded_rect_outline_points_core regression: fail");
    end
    $finish;
  end

endmodule
